// ----- src/uct_pkg.sv -----
// Shared types and constants for the usage count table core.
// Used by uct_table, uct_mul and the top level.
package uct_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ID_W    = 32;
    localparam int CNT_W   = 16;
    localparam int TURN_W  = 32;
    localparam int STEP_W  = 8;
    localparam int PEN_W   = 24;
    localparam int MUL_W   = 19;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [PEN_W-1:0]  BASE_PCT   = PEN_W'(100);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(40);
    localparam logic [TURN_W-1:0] DECAY_DIV  = TURN_W'(20);
    localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

    // x / 5 == (x * DIV5_M) >> DIV5_SH, exact for every x below 2**19
    localparam logic [MUL_W-1:0]  DIV5_M  = MUL_W'(419431);
    localparam int                DIV5_SH = 21;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_DECAY  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  count;
        logic [TURN_W-1:0] turn;
    } t_entry;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
        t_entry               data;
    } t_wr;

endpackage

// ----- src/uct_table.sv -----
// Entry store: identifier, use count and last turn for every slot.
// Flop array, one read address and one write port. Depends on uct_pkg.
module uct_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [uct_pkg::IDX_W-1:0] i_rd_addr,
    input  uct_pkg::t_wr             i_wr,
    output uct_pkg::t_entry          o_rd
);
    import uct_pkg::*;

    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd = r_mem[i_rd_addr];

endmodule

// ----- src/uct_mul.sv -----
// Shared unsigned multiplier with registered product.
// Serves both the penalty product and the divide-by-five step. Depends on uct_pkg.
module uct_mul (
    input  logic                        i_clk,
    input  logic [uct_pkg::MUL_W-1:0]   i_a,
    input  logic [uct_pkg::MUL_W-1:0]   i_b,
    output logic [uct_pkg::PROD_W-1:0]  o_p
);
    import uct_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/usage_count_table_lru_decay_core.sv -----
// Top level: sequencer, output register and config register of the usage count table.
// Instantiates uct_table and uct_mul; depends on uct_pkg.
//
//  port group   dir  payload (low bit first)              when taken
//  s_axis_*     in   tdata: key_id, turn;    tuser: cmd   tvalid & tready
//  m_axis_*     out  tdata: penalty_pct;     tuser: hit   tvalid & tready
//  i_cfg_*      in   wdata: penalty_step_pct              i_cfg_we high
//
// One word at a time: tready is high only while the sequencer is idle.
// Slots are scanned one per cycle; a decay also passes through ST_DMUL for each slot
// that needs the divide-by-20 product.
// A finished result waits in the output register; the next word is taken meanwhile.
// Synchronous active-low reset clears the table and the step register to 40.
module usage_count_table_lru_decay_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key_id, [63:32] turn
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] penalty_pct
    output logic        m_axis_tuser,   // [0] hit
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata     // [7:0] penalty_step_pct
);
    import uct_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_PEN   = 7'b0000100,
        ST_REC   = 7'b0001000,
        ST_DSCAN = 7'b0010000,
        ST_DMUL  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [ID_W-1:0]    r_id, n_id;
    logic [TURN_W-1:0]  r_turn, n_turn;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_zfound, n_zfound;
    logic [IDX_W-1:0]   r_zidx, n_zidx;
    logic [IDX_W-1:0]   r_oidx, n_oidx;
    logic [TURN_W-1:0]  r_oturn, n_oturn;
    logic               r_hit, n_hit;
    logic [PEN_W-1:0]   r_pen, n_pen;
    logic               r_ovalid, n_ovalid;
    logic [PEN_W-1:0]   r_open, n_open;
    logic               r_ohit, n_ohit;
    logic [STEP_W-1:0]  r_step;

    t_entry             rd;
    t_wr                wr;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  prod;

    logic               last, is_match, is_zero, is_older;
    logic [TURN_W-1:0]  age;
    logic [20:0]        thr;
    logic [CNT_W-1:0]   base_cnt;
    logic [CNT_W-1:0]   drop;
    logic               accept;

    uct_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_idx),
        .i_wr      (wr),
        .o_rd      (rd)
    );

    uct_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_open;
    assign m_axis_tuser  = r_ohit;

    assign last     = (r_idx == IDX_W'(ENTRIES - 1));
    assign is_match = (rd.id == r_id);
    assign is_zero  = (rd.count == '0);
    assign is_older = (r_idx == '0) || (rd.turn < r_oturn);
    assign age      = (r_turn > rd.turn) ? (r_turn - rd.turn) : '0;
    // 20 * count, no wider than 21 bits
    assign thr      = {1'b0, rd.count, 4'b0000} + {3'b000, rd.count, 2'b00};
    assign base_cnt = r_hit ? rd.count : '0;
    assign drop     = prod[DIV5_SH +: CNT_W];

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_id     = r_id;
        n_turn   = r_turn;
        n_idx    = r_idx;
        n_zfound = r_zfound;
        n_zidx   = r_zidx;
        n_oidx   = r_oidx;
        n_oturn  = r_oturn;
        n_hit    = r_hit;
        n_pen    = r_pen;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_open   = r_open;
        n_ohit   = r_ohit;
        mul_a    = {{(MUL_W - CNT_W){1'b0}}, rd.count};
        mul_b    = {{(MUL_W - STEP_W){1'b0}}, r_step};
        wr       = '0;
        wr.addr  = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd    = t_cmd'(s_axis_tuser);
                    n_id     = s_axis_tdata[31:0];
                    n_turn   = s_axis_tdata[63:32];
                    n_idx    = '0;
                    n_zfound = 1'b0;
                    n_hit    = 1'b0;
                    n_pen    = '0;
                    case (t_cmd'(s_axis_tuser))
                        CMD_RECORD, CMD_QUERY: n_state = ST_SCAN;
                        CMD_DECAY:             n_state = ST_DSCAN;
                        default:               n_state = ST_DONE;
                    endcase
                end
            end

            ST_SCAN: begin
                if (is_zero && !r_zfound) begin
                    n_zfound = 1'b1;
                    n_zidx   = r_idx;
                end
                if (is_older) begin
                    n_oidx  = r_idx;
                    n_oturn = rd.turn;
                end
                if (is_match) begin
                    // first match wins; slot stays at r_idx
                    n_hit   = 1'b1;
                    n_state = (r_cmd == CMD_QUERY) ? ST_PEN : ST_REC;
                end else if (last) begin
                    if (r_cmd == CMD_QUERY) begin
                        n_pen   = BASE_PCT;
                        n_state = ST_DONE;
                    end else begin
                        if (r_zfound)      n_idx = r_zidx;
                        else if (is_zero)  n_idx = r_idx;
                        else if (is_older) n_idx = r_idx;
                        else               n_idx = r_oidx;
                        n_state = ST_REC;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_PEN: begin
                n_pen   = prod[PEN_W-1:0] + BASE_PCT;
                n_state = ST_DONE;
            end

            ST_REC: begin
                wr.en         = 1'b1;
                wr.data.id    = r_id;
                wr.data.count = (base_cnt == COUNT_MAX) ? COUNT_MAX : base_cnt + CNT_W'(1);
                wr.data.turn  = r_turn;
                n_state       = ST_DONE;
            end

            ST_DSCAN: begin
                if (is_zero || age < DECAY_DIV) begin
                    if (last) n_state = ST_DONE;
                    else      n_idx   = r_idx + IDX_W'(1);
                end else if (age >= TURN_W'(thr)) begin
                    wr.en         = 1'b1;
                    wr.data.id    = rd.id;
                    wr.data.count = '0;
                    wr.data.turn  = r_turn;
                    if (last) n_state = ST_DONE;
                    else      n_idx   = r_idx + IDX_W'(1);
                end else begin
                    // age < 2**21 here; age/20 = (age/4)/5
                    mul_a   = age[20:2];
                    mul_b   = DIV5_M;
                    n_state = ST_DMUL;
                end
            end

            ST_DMUL: begin
                wr.en         = 1'b1;
                wr.data.id    = rd.id;
                wr.data.count = rd.count - drop;
                wr.data.turn  = r_turn;
                if (last) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_DSCAN;
                end
            end

            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_open   = r_pen;
                    n_ohit   = r_hit;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_step   <= STEP_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_id     <= n_id;
        r_turn   <= n_turn;
        r_idx    <= n_idx;
        r_zfound <= n_zfound;
        r_zidx   <= n_zidx;
        r_oidx   <= n_oidx;
        r_oturn  <= n_oturn;
        r_hit    <= n_hit;
        r_pen    <= n_pen;
        r_open   <= n_open;
        r_ohit   <= n_ohit;
    end

endmodule

// ----- src/uct_chk.sv -----
// Port-level checker for usage_count_table_lru_decay_core, bound to the top level.
// Sees the top-level ports only; depends on nothing else.
module uct_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        i_cfg_we,
    input logic [7:0]  i_cfg_wdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed under stall");

    // one word in flight: busy straight after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before work finished");

    // a nonzero penalty is always a query result, so never below the base
    a_pen_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata != 24'd0 |-> m_axis_tdata >= 24'd100)
        else $error("penalty below base value");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind usage_count_table_lru_decay_core uct_chk u_chk (.*);
